[design/rtdh_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, command and status codes, sequencer states and store port
// structs for the request table with completed-ID history. No dependencies.

package rtdh_pkg;

    // Payload widths of the channels and the configuration register.
    localparam int CMD_W  = 3;
    localparam int ID_W   = 64;
    localparam int STS_W  = 3;
    localparam int PCNT_W = 5;
    localparam int LIM_W  = 5;

    // Storage sizes.
    localparam int TABLE_DEPTH = 16;
    localparam int HIST_DEPTH  = 16;

    // Derived index and counter widths.
    localparam int TBL_AW = $clog2(TABLE_DEPTH);
    localparam int HIS_AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int IDX_W  = (TBL_AW > HIS_AW) ? TBL_AW : HIS_AW;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int HCNT_W = $clog2(HIST_DEPTH + 1);
    localparam int CMPL_W = (HCNT_W > LIM_W) ? HCNT_W : LIM_W;

    // Reset value of the history limit register.
    localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(16);

    // Command codes; codes six and seven are unused.
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DRAIN  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    // Result status codes.
    localparam logic [STS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STS_W-1:0] STS_CONFLICT = 3'd1;
    localparam logic [STS_W-1:0] STS_DUP      = 3'd2;
    localparam logic [STS_W-1:0] STS_SERVICED = 3'd3;
    localparam logic [STS_W-1:0] STS_FULL     = 3'd4;
    localparam logic [STS_W-1:0] STS_NONE     = 3'd5;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TSCAN,
        ST_STAMP,
        ST_HSCAN,
        ST_HMIN,
        ST_HREPL,
        ST_TRIM,
        ST_TMIN,
        ST_DCLR,
        ST_EMIT
    } rtdh_state_t;

    // Write requests from the sequencer to the store.
    typedef struct packed {
        logic              t_set;
        logic              t_del;
        logic              t_hand;
        logic              t_clr;
        logic [TBL_AW-1:0] t_idx;
        logic [ID_W-1:0]   t_seq;
        logic [ID_W-1:0]   t_stamp;
        logic              h_set;
        logic              h_del;
        logic              h_clr;
        logic [HIS_AW-1:0] h_idx;
        logic [ID_W-1:0]   h_seq;
    } rtdh_wr_t;

    // Read data from the store at the two scan addresses.
    typedef struct packed {
        logic            t_valid;
        logic            t_hand;
        logic [ID_W-1:0] t_seq;
        logic [ID_W-1:0] t_stamp;
        logic            h_valid;
        logic [ID_W-1:0] h_seq;
    } rtdh_rd_t;

endpackage

[design/rtdh_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request beats and result beats.
// Depends on rtdh_pkg for the payload widths.

interface rtdh_req_if import rtdh_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  seq_id;
    logic [ID_W-1:0]  stamp;

    modport source (output valid, cmd, seq_id, stamp, input ready);
    modport sink (input valid, cmd, seq_id, stamp, output ready);
endinterface

interface rtdh_rsp_if import rtdh_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic [ID_W-1:0]   out_seq_id;
    logic [ID_W-1:0]   out_stamp;
    logic [PCNT_W-1:0] pending_count;
    logic              last;

    modport source (output valid, status, out_seq_id, out_stamp, pending_count, last,
                    input ready);
    modport sink (input valid, status, out_seq_id, out_stamp, pending_count, last,
                  output ready);
endinterface

[design/rtdh_cmp.sv]
`timescale 1ns / 1ps
// Shared 64-bit compare unit: equality and unsigned less-than of two operands.
// Depends on rtdh_pkg for the ID width.

module rtdh_cmp import rtdh_pkg::*;
(
    input  logic [ID_W-1:0] a,
    input  logic [ID_W-1:0] b,
    output logic            eq,
    output logic            lt
);

    // One wide magnitude compare serves every search of the sequencer.
    assign eq = (a == b);
    assign lt = (a < b);

endmodule

[design/rtdh_store.sv]
`timescale 1ns / 1ps
// Storage of the pending request table and the completed-ID history.
// Valid and handed-out bits are flops; IDs and stamps are plain registers.
// Depends on rtdh_pkg for sizes and the read/write structs.

module rtdh_store import rtdh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rtdh_wr_t          wr,
    input  logic [TBL_AW-1:0] t_ridx,
    input  logic [HIS_AW-1:0] h_ridx,
    output rtdh_rd_t          rd
);

    logic [TABLE_DEPTH-1:0] t_valid_reg;
    logic [TABLE_DEPTH-1:0] t_hand_reg;
    logic [ID_W-1:0]        t_seq_reg   [TABLE_DEPTH];
    logic [ID_W-1:0]        t_stamp_reg [TABLE_DEPTH];
    logic [HIST_DEPTH-1:0]  h_valid_reg;
    logic [ID_W-1:0]        h_seq_reg   [HIST_DEPTH];

    // Table flags: a clear-all wins over single-entry updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= '0;
            t_hand_reg  <= '0;
        end
        else if (wr.t_clr)
        begin
            t_valid_reg <= '0;
            t_hand_reg  <= '0;
        end
        else
        begin
            if (wr.t_set)
            begin
                t_valid_reg[wr.t_idx] <= 1'b1;
                t_hand_reg[wr.t_idx]  <= 1'b0;
            end
            if (wr.t_del)
            begin
                t_valid_reg[wr.t_idx] <= 1'b0;
                t_hand_reg[wr.t_idx]  <= 1'b0;
            end
            if (wr.t_hand)
            begin
                t_hand_reg[wr.t_idx] <= 1'b1;
            end
        end
    end

    // Table payload is only read behind a set valid bit.
    always_ff @(posedge clk)
    begin
        if (wr.t_set)
        begin
            t_seq_reg[wr.t_idx]   <= wr.t_seq;
            t_stamp_reg[wr.t_idx] <= wr.t_stamp;
        end
    end

    // History valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= '0;
        end
        else if (wr.h_clr)
        begin
            h_valid_reg <= '0;
        end
        else
        begin
            if (wr.h_set)
            begin
                h_valid_reg[wr.h_idx] <= 1'b1;
            end
            if (wr.h_del)
            begin
                h_valid_reg[wr.h_idx] <= 1'b0;
            end
        end
    end

    // History IDs.
    always_ff @(posedge clk)
    begin
        if (wr.h_set)
        begin
            h_seq_reg[wr.h_idx] <= wr.h_seq;
        end
    end

    // Read ports at the scan addresses.
    always_comb
    begin
        rd.t_valid = t_valid_reg[t_ridx];
        rd.t_hand  = t_hand_reg[t_ridx];
        rd.t_seq   = t_seq_reg[t_ridx];
        rd.t_stamp = t_stamp_reg[t_ridx];
        rd.h_valid = h_valid_reg[h_ridx];
        rd.h_seq   = h_seq_reg[h_ridx];
    end

endmodule

[design/request_table_with_dedup_history_core.sv]
`timescale 1ns / 1ps
// Top level: scan sequencer, result output register and history limit register.
// Depends on rtdh_pkg, rtdh_ifs, rtdh_cmp and rtdh_store.
//
//  Channel | Dir | Handshake        | Beat contents
//  --------+-----+------------------+------------------------------------------------
//  req     | in  | valid/ready      | cmd, seq_id, stamp
//  rsp     | out | valid/ready      | status, out_seq_id, out_stamp, pending_count, last
//  cfg     | in  | cfg_we, no ready | cfg_wdata = history_limit
//
// One request beat at a time; req.ready is high only while the sequencer is idle.
// Each search runs one entry per cycle through the shared 64-bit comparator.
// Reset is asynchronous and clears all valid bits at once; there is no clearing pass.
// A stalled rsp only holds the sequencer in its emit state; the result register
// lets the next request beat in while the final result still waits.

module request_table_with_dedup_history_core import rtdh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    rtdh_req_if.sink         req,
    rtdh_rsp_if.source       rsp,
    input  logic             cfg_we,
    input  logic [LIM_W-1:0] cfg_wdata
);

    rtdh_state_t        state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [ID_W-1:0]    key_reg, key_next;
    logic [ID_W-1:0]    ts_reg, ts_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               hhit_reg, hhit_next;
    logic               tfree_reg, tfree_next;
    logic [IDX_W-1:0]   tfree_idx_reg, tfree_idx_next;
    logic               hfree_reg, hfree_next;
    logic [IDX_W-1:0]   hfree_idx_reg, hfree_idx_next;
    logic               best_reg, best_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [ID_W-1:0]    best_val_reg, best_val_next;
    logic [ID_W-1:0]    best_stamp_reg, best_stamp_next;
    logic               hmode_reg, hmode_next;
    logic [TABLE_DEPTH-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   pend_reg, pend_next;
    logic [HCNT_W-1:0]  hcnt_reg, hcnt_next;
    logic [LIM_W-1:0]   limit_reg;
    logic [STS_W-1:0]   res_status_reg, res_status_next;
    logic [ID_W-1:0]    res_seq_reg, res_seq_next;
    logic [ID_W-1:0]    res_stamp_reg, res_stamp_next;
    logic               res_last_reg, res_last_next;

    // Output register.
    logic               ov_reg;
    logic [STS_W-1:0]   o_status_reg;
    logic [ID_W-1:0]    o_seq_reg;
    logic [ID_W-1:0]    o_stamp_reg;
    logic [PCNT_W-1:0]  o_cnt_reg;
    logic               o_last_reg;

    logic               emit;
    logic               out_free;
    logic               t_last;
    logic               h_last;
    logic               trim_need;
    logic [CMPL_W-1:0]  lim_eff;
    rtdh_state_t        after_ins;
    logic               masked;
    logic [ID_W-1:0]    cmp_a;
    logic [ID_W-1:0]    cmp_b;
    logic               cmp_eq;
    logic               cmp_lt;
    rtdh_wr_t           wr;
    rtdh_rd_t           rd;
    logic [TBL_AW-1:0]  t_ridx;

    rtdh_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .t_ridx (t_ridx),
        .h_ridx (idx_reg[HIS_AW-1:0]),
        .rd     (rd)
    );

    rtdh_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .eq (cmp_eq),
        .lt (cmp_lt)
    );

    // Scan bookkeeping and the effective history limit.
    assign t_last    = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign h_last    = (idx_reg == IDX_W'(HIST_DEPTH - 1));
    assign lim_eff   = (CMPL_W'(limit_reg) > CMPL_W'(HIST_DEPTH)) ? CMPL_W'(HIST_DEPTH)
                                                                  : CMPL_W'(limit_reg);
    assign trim_need = (CMPL_W'(hcnt_reg) > lim_eff);
    assign after_ins = (cmd_reg == CMD_DRAIN && !res_last_reg) ? ST_TMIN : ST_TRIM;
    assign masked    = (cmd_reg == CMD_GET) ? rd.t_hand : mask_reg[idx_reg[TBL_AW-1:0]];
    assign t_ridx    = (state_reg == ST_STAMP) ? hit_idx_reg[TBL_AW-1:0]
                                               : idx_reg[TBL_AW-1:0];
    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // Operand selection for the shared comparator.
    always_comb
    begin
        unique case (state_reg)
            ST_STAMP:
            begin
                cmp_a = rd.t_stamp;
                cmp_b = ts_reg;
            end
            ST_TMIN:
            begin
                cmp_a = rd.t_seq;
                cmp_b = best_val_reg;
            end
            ST_HSCAN:
            begin
                cmp_a = rd.h_seq;
                cmp_b = key_reg;
            end
            ST_HMIN:
            begin
                cmp_a = rd.h_seq;
                cmp_b = best_val_reg;
            end
            ST_HREPL:
            begin
                cmp_a = best_val_reg;
                cmp_b = key_reg;
            end
            default:
            begin
                cmp_a = rd.t_seq;
                cmp_b = key_reg;
            end
        endcase
    end

    // Sequencer state and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            hcnt_reg  <= '0;
            mask_reg  <= '0;
            hmode_reg <= 1'b0;
            best_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            hcnt_reg  <= hcnt_next;
            mask_reg  <= mask_next;
            hmode_reg <= hmode_next;
            best_reg  <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        ts_reg         <= ts_next;
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hhit_reg       <= hhit_next;
        tfree_reg      <= tfree_next;
        tfree_idx_reg  <= tfree_idx_next;
        hfree_reg      <= hfree_next;
        hfree_idx_reg  <= hfree_idx_next;
        best_idx_reg   <= best_idx_next;
        best_val_reg   <= best_val_next;
        best_stamp_reg <= best_stamp_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_seq_reg    <= res_seq_next;
        res_stamp_reg  <= res_stamp_next;
        res_last_reg   <= res_last_next;
    end

    // History limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Next state, store writes and result staging.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        ts_next         = ts_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hhit_next       = hhit_reg;
        tfree_next      = tfree_reg;
        tfree_idx_next  = tfree_idx_reg;
        hfree_next      = hfree_reg;
        hfree_idx_next  = hfree_idx_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_val_next   = best_val_reg;
        best_stamp_next = best_stamp_reg;
        hmode_next      = hmode_reg;
        mask_next       = mask_reg;
        k_next          = k_reg;
        pend_next       = pend_reg;
        hcnt_next       = hcnt_reg;
        res_status_next = res_status_reg;
        res_seq_next    = res_seq_reg;
        res_stamp_next  = res_stamp_reg;
        res_last_next   = res_last_reg;
        wr              = '0;
        emit            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next        = req.cmd;
                    key_next        = req.seq_id;
                    ts_next         = req.stamp;
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    hhit_next       = 1'b0;
                    tfree_next      = 1'b0;
                    hfree_next      = 1'b0;
                    best_next       = 1'b0;
                    hmode_next      = 1'b0;
                    mask_next       = '0;
                    k_next          = '0;
                    res_status_next = STS_NONE;
                    res_seq_next    = '0;
                    res_stamp_next  = '0;
                    res_last_next   = 1'b1;
                    unique case (req.cmd)
                        CMD_PUSH, CMD_REMOVE:
                        begin
                            state_next = ST_TSCAN;
                        end
                        CMD_GET:
                        begin
                            state_next = ST_TMIN;
                        end
                        CMD_LIST:
                        begin
                            state_next = (pend_reg == '0) ? ST_EMIT : ST_TMIN;
                        end
                        CMD_DRAIN:
                        begin
                            state_next = (pend_reg == '0) ? ST_TRIM : ST_TMIN;
                        end
                        CMD_CLEAR:
                        begin
                            wr.t_clr        = 1'b1;
                            wr.h_clr        = 1'b1;
                            pend_next       = '0;
                            hcnt_next       = '0;
                            res_status_next = STS_OK;
                            state_next      = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            // Table search for the key, also noting the first free slot; remove deletes the entry found.
            ST_TSCAN:
            begin
                if (rd.t_valid && cmp_eq && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                end
                if (!rd.t_valid && !tfree_reg)
                begin
                    tfree_next     = 1'b1;
                    tfree_idx_next = idx_reg;
                end
                if (t_last)
                begin
                    idx_next = '0;
                    if (cmd_reg == CMD_PUSH)
                    begin
                        state_next = hit_next ? ST_STAMP : ST_HSCAN;
                    end
                    else
                    begin
                        if (hit_next)
                        begin
                            wr.t_del        = 1'b1;
                            wr.t_idx        = hit_idx_next[TBL_AW-1:0];
                            pend_next       = pend_reg - 1'b1;
                            res_status_next = STS_OK;
                        end
                        else
                        begin
                            res_status_next = STS_NONE;
                        end
                        state_next = ST_HSCAN;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Pending ID found on push: same stamp is a duplicate.
            ST_STAMP:
            begin
                res_status_next = cmp_eq ? STS_DUP : STS_CONFLICT;
                state_next      = ST_EMIT;
            end

            // History search for the key, also noting the first free slot.
            ST_HSCAN:
            begin
                if (rd.h_valid && cmp_eq)
                begin
                    hhit_next = 1'b1;
                end
                if (!rd.h_valid && !hfree_reg)
                begin
                    hfree_next     = 1'b1;
                    hfree_idx_next = idx_reg;
                end
                if (h_last)
                begin
                    idx_next = '0;
                    if (cmd_reg == CMD_PUSH)
                    begin
                        if (hhit_next)
                        begin
                            res_status_next = STS_SERVICED;
                        end
                        else if (tfree_reg)
                        begin
                            wr.t_set        = 1'b1;
                            wr.t_idx        = tfree_idx_reg[TBL_AW-1:0];
                            wr.t_seq        = key_reg;
                            wr.t_stamp      = ts_reg;
                            pend_next       = pend_reg + 1'b1;
                            res_status_next = STS_OK;
                        end
                        else
                        begin
                            res_status_next = STS_FULL;
                        end
                        state_next = ST_EMIT;
                    end
                    else if (hhit_next)
                    begin
                        best_next  = 1'b0;
                        state_next = after_ins;
                    end
                    else if (hfree_next)
                    begin
                        wr.h_set   = 1'b1;
                        wr.h_idx   = hfree_idx_next[HIS_AW-1:0];
                        wr.h_seq   = key_reg;
                        hcnt_next  = hcnt_reg + 1'b1;
                        best_next  = 1'b0;
                        state_next = after_ins;
                    end
                    else
                    begin
                        best_next  = 1'b0;
                        hmode_next = 1'b0;
                        state_next = ST_HMIN;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Smallest history ID, for replacement or for trimming.
            ST_HMIN:
            begin
                if (rd.h_valid && (!best_reg || cmp_lt))
                begin
                    best_next     = 1'b1;
                    best_idx_next = idx_reg;
                    best_val_next = rd.h_seq;
                end
                if (h_last)
                begin
                    idx_next = '0;
                    if (hmode_reg)
                    begin
                        wr.h_del   = 1'b1;
                        wr.h_idx   = best_idx_next[HIS_AW-1:0];
                        hcnt_next  = hcnt_reg - 1'b1;
                        state_next = ST_TRIM;
                    end
                    else
                    begin
                        state_next = ST_HREPL;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Full history: a higher key replaces the smallest ID.
            ST_HREPL:
            begin
                if (best_reg && cmp_lt)
                begin
                    wr.h_set = 1'b1;
                    wr.h_idx = best_idx_reg[HIS_AW-1:0];
                    wr.h_seq = key_reg;
                end
                best_next  = 1'b0;
                state_next = after_ins;
            end

            // Drop smallest IDs one pass at a time until the limit holds.
            ST_TRIM:
            begin
                if (trim_need)
                begin
                    idx_next   = '0;
                    best_next  = 1'b0;
                    hmode_next = 1'b1;
                    state_next = ST_HMIN;
                end
                else
                begin
                    hmode_next = 1'b0;
                    state_next = (cmd_reg == CMD_DRAIN) ? ST_DCLR : ST_EMIT;
                end
            end

            // Lowest pending ID not yet handed out (get next) or emitted (list, drain).
            ST_TMIN:
            begin
                if (rd.t_valid && !masked && (!best_reg || cmp_lt))
                begin
                    best_next       = 1'b1;
                    best_idx_next   = idx_reg;
                    best_val_next   = rd.t_seq;
                    best_stamp_next = rd.t_stamp;
                end
                if (t_last)
                begin
                    idx_next = '0;
                    if (cmd_reg == CMD_GET)
                    begin
                        if (best_next)
                        begin
                            wr.t_hand       = 1'b1;
                            wr.t_idx        = best_idx_next[TBL_AW-1:0];
                            res_status_next = STS_OK;
                            res_seq_next    = best_val_next;
                            res_stamp_next  = best_stamp_next;
                        end
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        mask_next[best_idx_next[TBL_AW-1:0]] = 1'b1;
                        k_next          = k_reg + 1'b1;
                        res_status_next = STS_OK;
                        res_seq_next    = best_val_next;
                        res_stamp_next  = best_stamp_next;
                        res_last_next   = (CNT_W'(k_reg + 1'b1) == pend_reg);
                        key_next        = best_val_next;
                        hhit_next       = 1'b0;
                        hfree_next      = 1'b0;
                        best_next       = 1'b0;
                        if (cmd_reg == CMD_DRAIN && res_last_next)
                        begin
                            state_next = ST_HSCAN;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // End of drain: the table empties after the history is settled.
            ST_DCLR:
            begin
                wr.t_clr   = 1'b1;
                pend_next  = '0;
                state_next = ST_EMIT;
            end

            // Hand the staged result to the output register.
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (cmd_reg == CMD_LIST && !res_last_reg)
                    begin
                        state_next = ST_TMIN;
                    end
                    else if (cmd_reg == CMD_DRAIN && !res_last_reg)
                    begin
                        state_next = ST_HSCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loads on emit, empties when the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (emit)
        begin
            ov_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            o_status_reg <= res_status_reg;
            o_seq_reg    <= res_seq_reg;
            o_stamp_reg  <= res_stamp_reg;
            o_cnt_reg    <= (cmd_reg == CMD_DRAIN) ? '0 : PCNT_W'(pend_reg);
            o_last_reg   <= res_last_reg;
        end
    end

    assign rsp.valid         = ov_reg;
    assign rsp.status        = o_status_reg;
    assign rsp.out_seq_id    = o_seq_reg;
    assign rsp.out_stamp     = o_stamp_reg;
    assign rsp.pending_count = o_cnt_reg;
    assign rsp.last          = o_last_reg;

    // The pending count never exceeds the table size.
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CNT_W'(TABLE_DEPTH))
        else $error("pending count beyond table depth");

    // The history count never exceeds the history size.
    a_hcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hcnt_reg <= HCNT_W'(HIST_DEPTH))
        else $error("history count beyond history depth");

    // A result appears only out of the emit state.
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result register loaded outside emit state");

    // The stamp check only follows a table hit.
    a_stamp_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STAMP) |-> hit_reg)
        else $error("stamp compare without a table hit");

    // Replacement only runs on a full history with a minimum found.
    a_repl_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HREPL) |-> (best_reg && hcnt_reg == HCNT_W'(HIST_DEPTH)))
        else $error("history replacement while not full");

endmodule

[tb/rtdh_checker.sv]
`timescale 1ns / 1ps
// Checker for the request table with completed-ID history: it watches the request,
// result and configuration ports, predicts every result beat and compares them.
// Depends on rtdh_pkg and rtdh_ifs.

module rtdh_checker import rtdh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    rtdh_req_if              req,
    rtdh_rsp_if              rsp,
    input  logic             cfg_we,
    input  logic [LIM_W-1:0] cfg_wdata,
    output int               mismatch_count,
    output int               results_owed
);

    // One predicted result beat.
    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [ID_W-1:0]   seq_id;
        logic [ID_W-1:0]   stamp;
        logic [PCNT_W-1:0] pend;
        logic              last;
    } result_t;

    result_t owed_results[$];
    result_t want;

    // Shadow copy of the pending table, the completed history and the limit.
    bit              slot_used  [TABLE_DEPTH];
    bit              slot_given [TABLE_DEPTH];
    logic [ID_W-1:0] slot_seq   [TABLE_DEPTH];
    logic [ID_W-1:0] slot_stamp [TABLE_DEPTH];
    bit              hist_used  [HIST_DEPTH];
    logic [ID_W-1:0] hist_seq   [HIST_DEPTH];
    logic [LIM_W-1:0] limit_reg;

    // Slot indexes of the pending entries in ascending ID order.
    int order [TABLE_DEPTH];

    task automatic report_mismatch(string what, logic [ID_W-1:0] got, logic [ID_W-1:0] exp_v);
        $display("%0t: result beat %s mismatch: got %0h, expected %0h", $time, what, got, exp_v);
        mismatch_count++;
    endtask

    function automatic void owe(logic [STS_W-1:0] sts, logic [ID_W-1:0] id,
                                logic [ID_W-1:0] ts, int pend, bit last);
        result_t r;
        r.status = sts;
        r.seq_id = id;
        r.stamp  = ts;
        r.pend   = PCNT_W'(pend);
        r.last   = last;
        owed_results.push_back(r);
    endfunction

    function automatic int find_slot(logic [ID_W-1:0] id);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_used[i] && slot_seq[i] == id) return i;
        return -1;
    endfunction

    function automatic int count_pending();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_used[i]) n++;
        return n;
    endfunction

    function automatic bit in_history(logic [ID_W-1:0] id);
        for (int i = 0; i < HIST_DEPTH; i++)
            if (hist_used[i] && hist_seq[i] == id) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int history_min_slot();
        int m;
        m = -1;
        for (int i = 0; i < HIST_DEPTH; i++)
            if (hist_used[i] && (m < 0 || hist_seq[i] < hist_seq[m])) m = i;
        return m;
    endfunction

    // Retire an ID; a full history keeps the highest IDs.
    function automatic void retire_id(logic [ID_W-1:0] id);
        int m;
        if (in_history(id)) return;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            if (!hist_used[i]) begin
                hist_used[i] = 1'b1;
                hist_seq[i]  = id;
                return;
            end
        end
        m = history_min_slot();
        if (m >= 0 && id > hist_seq[m]) hist_seq[m] = id;
    endfunction

    // Drop the lowest IDs until the history fits the limit in use.
    function automatic void trim_history();
        int lim;
        int n;
        int m;
        lim = (limit_reg > HIST_DEPTH) ? HIST_DEPTH : int'(limit_reg);
        n = 0;
        for (int i = 0; i < HIST_DEPTH; i++)
            if (hist_used[i]) n++;
        while (n > lim) begin
            m = history_min_slot();
            if (m < 0) break;
            hist_used[m] = 1'b0;
            n--;
        end
    endfunction

    function automatic int sort_pending();
        int n;
        int j;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i]) begin
                j = n;
                while (j > 0 && slot_seq[order[j-1]] > slot_seq[i]) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
                n++;
            end
        end
        return n;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_used[i]  = 1'b0;
            slot_given[i] = 1'b0;
        end
    endfunction

    // Work out the result beats of one accepted request and update the shadow state.
    function automatic void predict_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                            logic [ID_W-1:0] ts);
        int s;
        int n;
        case (cmd)
            CMD_PUSH: begin
                s = find_slot(id);
                if (s >= 0) begin
                    owe((slot_stamp[s] == ts) ? STS_DUP : STS_CONFLICT, '0, '0,
                        count_pending(), 1'b1);
                end else if (in_history(id)) begin
                    owe(STS_SERVICED, '0, '0, count_pending(), 1'b1);
                end else begin
                    for (int i = 0; i < TABLE_DEPTH && s < 0; i++)
                        if (!slot_used[i]) s = i;
                    if (s < 0) begin
                        owe(STS_FULL, '0, '0, count_pending(), 1'b1);
                    end else begin
                        slot_used[s]  = 1'b1;
                        slot_given[s] = 1'b0;
                        slot_seq[s]   = id;
                        slot_stamp[s] = ts;
                        owe(STS_OK, '0, '0, count_pending(), 1'b1);
                    end
                end
            end
            CMD_GET: begin
                n = sort_pending();
                s = -1;
                for (int i = 0; i < n; i++)
                    if (s < 0 && !slot_given[order[i]]) s = order[i];
                if (s >= 0) begin
                    slot_given[s] = 1'b1;
                    owe(STS_OK, slot_seq[s], slot_stamp[s], count_pending(), 1'b1);
                end else begin
                    owe(STS_NONE, '0, '0, count_pending(), 1'b1);
                end
            end
            CMD_REMOVE: begin
                s = find_slot(id);
                if (s >= 0) begin
                    slot_used[s]  = 1'b0;
                    slot_given[s] = 1'b0;
                end
                retire_id(id);
                trim_history();
                owe((s >= 0) ? STS_OK : STS_NONE, '0, '0, count_pending(), 1'b1);
            end
            CMD_LIST, CMD_DRAIN: begin
                n = sort_pending();
                if (cmd == CMD_DRAIN) begin
                    for (int i = 0; i < n; i++) retire_id(slot_seq[order[i]]);
                    trim_history();
                end
                if (n == 0) owe(STS_NONE, '0, '0, count_pending(), 1'b1);
                for (int i = 0; i < n; i++)
                    owe(STS_OK, slot_seq[order[i]], slot_stamp[order[i]],
                        (cmd == CMD_DRAIN) ? 0 : n, i == n - 1);
                if (cmd == CMD_DRAIN) clear_table();
            end
            CMD_CLEAR: begin
                clear_table();
                for (int i = 0; i < HIST_DEPTH; i++) hist_used[i] = 1'b0;
                owe(STS_OK, '0, '0, 0, 1'b1);
            end
            default: begin
                // Unused command codes change nothing.
                owe(STS_NONE, '0, '0, count_pending(), 1'b1);
            end
        endcase
    endfunction

    // Compare result beats first, since a request taken at the same edge is younger.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_table();
            for (int i = 0; i < HIST_DEPTH; i++) hist_used[i] = 1'b0;
            limit_reg = LIMIT_RST;
            owed_results.delete();
            results_owed = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("with nothing owed, status", ID_W'(rsp.status), '0);
                end else begin
                    want = owed_results.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", ID_W'(rsp.status), ID_W'(want.status));
                    if (rsp.out_seq_id !== want.seq_id)
                        report_mismatch("out_seq_id", rsp.out_seq_id, want.seq_id);
                    if (rsp.out_stamp !== want.stamp)
                        report_mismatch("out_stamp", rsp.out_stamp, want.stamp);
                    if (rsp.pending_count !== want.pend)
                        report_mismatch("pending_count", ID_W'(rsp.pending_count),
                                        ID_W'(want.pend));
                    if (rsp.last !== want.last)
                        report_mismatch("last", ID_W'(rsp.last), ID_W'(want.last));
                end
            end
            if (req.valid && req.ready)
                predict_request(req.cmd, req.seq_id, req.stamp);
            if (cfg_we)
                limit_reg = cfg_wdata;
            results_owed = owed_results.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, request and result traffic, limit writes
// and the verdict. Depends on rtdh_pkg, rtdh_ifs, rtdh_checker and the core.

module testbench;
    import rtdh_pkg::*;

    // Command codes the block does not use.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int POOL_SIZE      = 24;
    localparam int PHASES         = 8;
    localparam int BEATS_PER_PHASE = 50;
    localparam logic [ID_W-1:0] ALL_ONES = '1;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [LIM_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int results_owed;
    int req_gap_max = 0;
    int rsp_gap_max = 0;
    int quiet_cycles = 0;

    // Shared IDs and stamps so that duplicates, conflicts and retired IDs recur.
    logic [ID_W-1:0] id_pool    [POOL_SIZE];
    logic [ID_W-1:0] stamp_pool [POOL_SIZE];

    rtdh_req_if req_bus ();
    rtdh_rsp_if rsp_bus ();

    request_table_with_dedup_history_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    rtdh_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_bus),
        .rsp            (rsp_bus),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always #5 clk = ~clk;

    // End the run when nothing has moved on either channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    // Result side: stall a random number of cycles before each beat.
    initial begin
        int stall;
        rsp_bus.ready = 1'b0;
        wait (rst_n);
        forever begin
            stall = (rsp_gap_max > 0) ? $urandom_range(rsp_gap_max, 0) : 0;
            if (stall > 0) begin
                rsp_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_bus.ready = 1'b1;
            do @(posedge clk); while (!rsp_bus.valid);
            @(negedge clk);
        end
    end

    // Present one request beat after a random gap and hold it until it is taken.
    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                             logic [ID_W-1:0] ts);
        int gap;
        gap = (req_gap_max > 0) ? $urandom_range(req_gap_max, 0) : 0;
        if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid  = 1'b1;
        req_bus.cmd    = cmd;
        req_bus.seq_id = id;
        req_bus.stamp  = ts;
        do @(posedge clk); while (!req_bus.ready);
        @(negedge clk);
    endtask

    // Stop sending, wait for every owed result, then let any trailing work finish.
    task automatic wait_drained();
        req_bus.valid = 1'b0;
        while (results_owed != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(logic [LIM_W-1:0] value);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Mostly pool IDs with their usual stamps; the rest are fresh 64-bit values.
    task automatic random_beat(int push_pct);
        int k;
        int roll;
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] ts;
        k  = $urandom_range(POOL_SIZE - 1, 0);
        id = ($urandom_range(9, 0) == 0) ? {$urandom, $urandom} : id_pool[k];
        ts = ($urandom_range(2, 0) == 0) ? {$urandom, $urandom} : stamp_pool[k];
        if ($urandom_range(99, 0) < push_pct) begin
            cmd = CMD_PUSH;
        end else begin
            roll = $urandom_range(99, 0);
            if (roll < 35)      cmd = CMD_GET;
            else if (roll < 65) cmd = CMD_REMOVE;
            else if (roll < 80) cmd = CMD_LIST;
            else if (roll < 92) cmd = CMD_DRAIN;
            else if (roll < 97) cmd = CMD_CLEAR;
            else                cmd = $urandom_range(1, 0) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        end
        send_beat(cmd, id, ts);
    endtask

    initial begin
        logic [LIM_W-1:0] limits [PHASES];
        req_bus.valid  = 1'b0;
        req_bus.cmd    = CMD_PUSH;
        req_bus.seq_id = '0;
        req_bus.stamp  = '0;

        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[i]    = {$urandom, $urandom};
            stamp_pool[i] = {$urandom, $urandom};
        end
        id_pool[0] = '0;
        id_pool[1] = ALL_ONES;

        limits = '{5'd16, 5'd0, 5'd1, 5'd3, 5'd8, 5'd15, 5'd16,
                   LIM_W'($urandom_range(HIST_DEPTH, 0))};

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed beats: empty table, retired IDs, extremes, duplicates and conflicts.
        req_gap_max = 2;
        rsp_gap_max = 2;
        send_beat(CMD_LIST, '0, '0);
        send_beat(CMD_DRAIN, '0, '0);
        send_beat(CMD_GET, '0, '0);
        send_beat(CMD_REMOVE, 64'd5, '0);
        send_beat(CMD_PUSH, 64'd5, 64'd9);
        send_beat(CMD_PUSH, '0, '0);
        send_beat(CMD_PUSH, ALL_ONES, ALL_ONES);
        send_beat(CMD_PUSH, '0, '0);
        send_beat(CMD_PUSH, '0, 64'd1);
        send_beat(CMD_GET, ALL_ONES, ALL_ONES);
        send_beat(CMD_GET, '0, '0);
        send_beat(CMD_GET, '0, '0);
        send_beat(CMD_LIST, '0, '0);
        send_beat(CMD_REMOVE, ALL_ONES, '0);
        send_beat(CMD_PUSH, 64'd7, 64'd3);
        send_beat(CMD_DRAIN, '0, '0);
        send_beat(CMD_PUSH, '0, '0);
        send_beat(CMD_CLEAR, '0, '0);
        send_beat(CMD_PUSH, 64'd5, 64'd9);
        send_beat(CMD_UNUSED_LO, ALL_ONES, ALL_ONES);
        send_beat(CMD_UNUSED_HI, '0, '0);

        // Random phases, each under its own history limit; odd phases fill the table.
        for (int p = 0; p < PHASES; p++) begin
            write_limit(limits[p]);
            for (int i = 0; i < BEATS_PER_PHASE; i++) begin
                if (i % 10 == 0) begin
                    req_gap_max = $urandom_range(1, 0) * 7;
                    rsp_gap_max = $urandom_range(1, 0) * 7;
                end
                random_beat((p % 2 == 1) ? 75 : 45);
            end
        end

        wait_drained();
        if (mismatch_count == 0 && results_owed == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
